// File: sv/irac_pkg.sv
// shared types and constants for the interval range assign counter
package irac_pkg;

  localparam int MaxIntervals = 64;
  localparam int PosW = 31;
  localparam logic [PosW-1:0] LineLenRst = 31'd1024;

  typedef logic [PosW-1:0] pos_t;

  typedef struct packed {
    pos_t fin;
    pos_t beg;
  } iv_t;

  typedef enum logic [3:0] {
    StInit,
    StIdle,
    StPrep,
    StLen,
    StSetup,
    StScan,
    StCheck,
    StWrite,
    StTail,
    StIns,
    StDone
  } state_e;

endpackage

// File: sv/irac_ram.sv
// interval table memory, one write port and one registered read port
module irac_ram #(
  parameter int Depth = irac_pkg::MaxIntervals,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  irac_pkg::iv_t        wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output irac_pkg::iv_t        rdata_o
);

  irac_pkg::iv_t mem [Depth];
  irac_pkg::iv_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/interval_range_assign_counter.sv
// interval range assign counter: fsm, scan datapath and table memory
// an empty range skips the table passes; an item that would overflow the table skips the rewrite pass
// throughput: one item at a time; count and rewrite passes stream the table one entry per cycle
// reset: the init state writes the full-line interval into entry 0, then items are taken
// configuration writes are taken while idle and reinitialize the table in the same cycle
module interval_range_assign_counter #(
  parameter int MAX_INTERVALS = irac_pkg::MaxIntervals
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [30:0]           cfg_line_length_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [30:0]           range_first_i,
  input  logic [30:0]           range_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [30:0]           set_count_o,
  output logic                  overflow_o
);

  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int NW = $clog2(MAX_INTERVALS + 1);
  localparam int CW = $clog2(MAX_INTERVALS + 3);

  irac_pkg::state_e state_q, state_d;

  irac_pkg::pos_t line_len_q, total_q;
  logic [NW-1:0]  count_q;
  logic           op_q;
  irac_pkg::pos_t first_q, last_q, lo_q, hi_q, setlen_q, acc_q;
  logic           empty_q;
  logic [NW-1:0]  ra_q, w_q;
  logic           rvalid_q;
  irac_pkg::pos_t ovl_q;
  logic [1:0]     inc_q;
  logic           stg_vld_q;
  logic [CW-1:0]  cnt_q;
  irac_pkg::iv_t  tail_q;
  logic           tail_vld_q;
  irac_pkg::pos_t res_cnt_q;
  logic           res_ovf_q;
  logic           out_valid_q;
  irac_pkg::pos_t set_count_q;
  logic           overflow_q;

  logic           cfg_fire, in_fire;
  logic           re;
  logic           we;
  logic [AW-1:0]  waddr;
  irac_pkg::iv_t  wdata;
  irac_pkg::iv_t  rd;

  // clipping of the request range
  irac_pkg::pos_t hi_c, fst_c;
  // classification of the entry just read
  logic           in_rng, from_below, tail_ex;
  irac_pkg::pos_t max_b, min_f, ovl_c;
  logic [1:0]     inc_c;
  logic           piece_vld;
  irac_pkg::iv_t  piece;
  logic [CW-1:0]  cnt_plus;
  logic           ovf_c;
  logic           scan_done, write_done;

  assign cfg_ready_o = (state_q == irac_pkg::StIdle);
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = (state_q == irac_pkg::StIdle);
  assign in_fire     = in_valid_i & in_ready_o;

  assign out_valid_o = out_valid_q;
  assign set_count_o = set_count_q;
  assign overflow_o  = overflow_q;

  irac_ram #(
    .Depth (MAX_INTERVALS),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (ra_q[AW-1:0]),
    .rdata_o (rd)
  );

  always_comb begin
    hi_c  = (last_q > line_len_q) ? line_len_q : last_q;
    fst_c = (first_q == '0) ? irac_pkg::pos_t'(1) : first_q;
  end

  always_comb begin
    in_rng     = (rd.beg >= lo_q) && (rd.beg < hi_q);
    from_below = (rd.beg < lo_q) && (rd.fin > lo_q);
    tail_ex    = (rd.fin > hi_q);
    max_b      = (rd.beg > lo_q) ? rd.beg : lo_q;
    min_f      = (rd.fin < hi_q) ? rd.fin : hi_q;
    ovl_c      = (in_rng || from_below) ? (min_f - max_b) : '0;
    if (in_rng) begin
      inc_c     = {1'b0, tail_ex};
      piece_vld = tail_ex;
      piece     = '{fin: rd.fin, beg: hi_q};
    end else if (from_below) begin
      inc_c     = tail_ex ? 2'd2 : 2'd1;
      piece_vld = 1'b1;
      piece     = '{fin: lo_q, beg: rd.beg};
    end else begin
      inc_c     = 2'd1;
      piece_vld = 1'b1;
      piece     = rd;
    end
  end

  assign cnt_plus   = cnt_q + CW'(op_q);
  assign ovf_c      = cnt_plus > CW'(MAX_INTERVALS);
  assign scan_done  = (ra_q == count_q) && !rvalid_q && !stg_vld_q;
  assign write_done = (ra_q == count_q) && !rvalid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      irac_pkg::StInit:  state_d = irac_pkg::StIdle;
      irac_pkg::StIdle:  if (in_fire) state_d = irac_pkg::StPrep;
      irac_pkg::StPrep:  state_d = irac_pkg::StLen;
      irac_pkg::StLen:   state_d = empty_q ? irac_pkg::StDone : irac_pkg::StSetup;
      irac_pkg::StSetup: state_d = irac_pkg::StScan;
      irac_pkg::StScan:  if (scan_done) state_d = irac_pkg::StCheck;
      irac_pkg::StCheck: state_d = ovf_c ? irac_pkg::StDone : irac_pkg::StWrite;
      irac_pkg::StWrite: if (write_done) state_d = irac_pkg::StTail;
      irac_pkg::StTail:  state_d = irac_pkg::StIns;
      irac_pkg::StIns:   state_d = irac_pkg::StDone;
      irac_pkg::StDone:  if (!out_valid_q || out_ready_i) state_d = irac_pkg::StIdle;
      default:           state_d = irac_pkg::StIdle;
    endcase
  end

  // memory controls
  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    waddr = w_q[AW-1:0];
    wdata = piece;
    case (state_q)
      irac_pkg::StScan,
      irac_pkg::StWrite: re = (ra_q < count_q);
      default:           re = 1'b0;
    endcase
    if (cfg_fire) begin
      we    = 1'b1;
      waddr = '0;
      wdata = '{fin: cfg_line_length_i, beg: '0};
    end else begin
      case (state_q)
        irac_pkg::StInit: begin
          we    = 1'b1;
          waddr = '0;
          wdata = '{fin: line_len_q, beg: '0};
        end
        irac_pkg::StWrite: begin
          we    = rvalid_q && piece_vld;
          wdata = piece;
        end
        irac_pkg::StTail: begin
          we    = tail_vld_q;
          wdata = tail_q;
        end
        irac_pkg::StIns: begin
          we    = op_q;
          wdata = '{fin: hi_q, beg: lo_q};
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= irac_pkg::StInit;
      line_len_q  <= irac_pkg::LineLenRst;
      total_q     <= irac_pkg::LineLenRst;
      count_q     <= NW'(1);
      ra_q        <= '0;
      w_q         <= '0;
      rvalid_q    <= 1'b0;
      stg_vld_q   <= 1'b0;
      cnt_q       <= '0;
      tail_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= re;
      if (re) begin
        ra_q <= ra_q + NW'(1);
      end
      stg_vld_q <= (state_q == irac_pkg::StScan) && rvalid_q;

      if (cfg_fire) begin
        line_len_q <= cfg_line_length_i;
        total_q    <= cfg_line_length_i;
        count_q    <= (cfg_line_length_i != '0) ? NW'(1) : '0;
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        irac_pkg::StSetup: begin
          ra_q  <= '0;
          cnt_q <= '0;
        end
        irac_pkg::StScan: begin
          if (stg_vld_q) begin
            cnt_q <= cnt_q + CW'(inc_q);
          end
        end
        irac_pkg::StCheck: begin
          ra_q       <= '0;
          w_q        <= '0;
          tail_vld_q <= 1'b0;
        end
        irac_pkg::StWrite: begin
          if (rvalid_q) begin
            if (piece_vld) begin
              w_q <= w_q + NW'(1);
            end
            if (from_below && tail_ex) begin
              tail_vld_q <= 1'b1;
            end
          end
        end
        irac_pkg::StTail: begin
          if (tail_vld_q) begin
            w_q <= w_q + NW'(1);
          end
        end
        irac_pkg::StIns: begin
          count_q <= w_q + NW'(op_q);
          total_q <= acc_q;
        end
        irac_pkg::StDone: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= operation_i;
      first_q <= range_first_i;
      last_q  <= range_last_i;
    end
    if (rvalid_q) begin
      ovl_q <= ovl_c;
      inc_q <= inc_c;
    end
    case (state_q)
      irac_pkg::StPrep: begin
        lo_q    <= fst_c - irac_pkg::pos_t'(1);
        hi_q    <= hi_c;
        empty_q <= fst_c > hi_c;
      end
      irac_pkg::StLen: begin
        setlen_q  <= op_q ? (hi_q - lo_q) : '0;
        res_cnt_q <= total_q;
        res_ovf_q <= 1'b0;
      end
      irac_pkg::StSetup: begin
        acc_q <= total_q + setlen_q;
      end
      irac_pkg::StScan: begin
        if (stg_vld_q) begin
          acc_q <= acc_q - ovl_q;
        end
      end
      irac_pkg::StCheck: begin
        res_cnt_q <= total_q;
        res_ovf_q <= ovf_c;
      end
      irac_pkg::StWrite: begin
        if (rvalid_q && from_below && tail_ex) begin
          tail_q <= '{fin: rd.fin, beg: hi_q};
        end
      end
      irac_pkg::StIns: begin
        res_cnt_q <= acc_q;
        res_ovf_q <= 1'b0;
      end
      irac_pkg::StDone: begin
        if (!out_valid_q || out_ready_i) begin
          set_count_q <= res_cnt_q;
          overflow_q  <= res_ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: tb/irac_tb_pkg.sv
// operation codes shared by the testbench modules
package irac_tb_pkg;

  localparam logic OpClear = 1'b0;
  localparam logic OpSet   = 1'b1;

endpackage

// File: tb/irac_checker.sv
// checker: tracks the interval table, predicts each set count and compares results
module irac_checker
  import irac_pkg::*;
  import irac_tb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  pos_t cfg_line_length_i,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  logic operation_i,
  input  pos_t range_first_i,
  input  pos_t range_last_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  pos_t set_count_i,
  input  logic overflow_i,
  output int   pending_o,
  output int   fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pos_t count;
    logic full;
  } tally_t;

  pos_t   line_len;
  pos_t   iv_beg  [MaxIntervals];
  pos_t   iv_fin  [MaxIntervals];
  logic   iv_used [MaxIntervals];
  pos_t   set_total;
  tally_t tally_q [$];
  tally_t want;
  int     fails = 0;

  assign fails_o = fails;

  function automatic void load_line(pos_t len);
    line_len = len;
    for (int i = 0; i < MaxIntervals; i++) begin
      iv_beg[i]  = '0;
      iv_fin[i]  = '0;
      iv_used[i] = 1'b0;
    end
    set_total = '0;
    if (len != '0) begin
      iv_fin[0]  = len;
      iv_used[0] = 1'b1;
      set_total  = len;
    end
  endfunction

  function automatic tally_t apply_range(logic op, pos_t first, pos_t last);
    pos_t   nb [2*MaxIntervals+1];
    pos_t   nf [2*MaxIntervals+1];
    int     n;
    pos_t   lo, hi, b, f;
    longint sum;
    tally_t res;
    res.count = set_total;
    res.full  = 1'b0;
    n   = 0;
    sum = 0;
    if (first == '0) first = pos_t'(1);
    if (last > line_len) last = line_len;
    if (first > last) return res;
    lo = first - pos_t'(1);
    hi = last;
    for (int i = 0; i < MaxIntervals; i++) begin
      if (!iv_used[i]) continue;
      b = iv_beg[i];
      f = iv_fin[i];
      if (b >= lo && b < hi) begin
        // starts inside the range, only a tail past it survives
        if (f > hi) begin
          nb[n] = hi; nf[n] = f; n++;
        end
      end else if (b < lo && f > lo) begin
        // reaches into the range from below, trim and maybe split
        nb[n] = b; nf[n] = lo; n++;
        if (f > hi) begin
          nb[n] = hi; nf[n] = f; n++;
        end
      end else begin
        nb[n] = b; nf[n] = f; n++;
      end
    end
    if (op == OpSet) begin
      nb[n] = lo; nf[n] = hi; n++;
    end
    if (n > MaxIntervals) begin
      res.full = 1'b1;
      return res;
    end
    for (int i = 0; i < MaxIntervals; i++) begin
      iv_used[i] = (i < n);
      iv_beg[i]  = (i < n) ? nb[i] : '0;
      iv_fin[i]  = (i < n) ? nf[i] : '0;
      if (i < n) sum += longint'(nf[i] - nb[i]);
    end
    set_total = pos_t'(sum);
    res.count = set_total;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_line(LineLenRst);
      tally_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) load_line(cfg_line_length_i);
      if (out_valid_i && out_ready_i) begin
        if (tally_q.size() == 0) begin
          $error("unexpected item: set_count %0d overflow %0b", set_count_i, overflow_i);
          fails++;
        end else begin
          want = tally_q.pop_front();
          if (set_count_i !== want.count) begin
            $error("set_count: expected %0d, actual %0d", want.count, set_count_i);
            fails++;
          end
          if (overflow_i !== want.full) begin
            $error("overflow: expected %0b, actual %0b", want.full, overflow_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        tally_q.insert(tally_q.size(),
                       apply_range(operation_i, range_first_i, range_last_i));
      end
      pending_o <= tally_q.size();
    end
  end

endmodule

// File: tb/tb.sv
// testbench top: drives range requests and line lengths, gives the verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import irac_pkg::*;
  import irac_tb_pkg::*;

  localparam int NumPhases = 9;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  pos_t cfg_len = '0;
  logic in_valid = 1'b0;
  logic in_op = OpClear;
  pos_t in_first = '0;
  pos_t in_last = '0;
  logic out_ready = 1'b0;
  logic cfg_ready, in_ready, out_valid, overflow;
  pos_t set_count;
  logic idle_en = 1'b1;
  pos_t cur_len = LineLenRst;
  int   pending, fails;

  interval_range_assign_counter dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_line_length_i(cfg_len),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (in_op),
    .range_first_i    (in_first),
    .range_last_i     (in_last),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .set_count_o      (set_count),
    .overflow_o       (overflow)
  );

  irac_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_line_length_i(cfg_len),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .operation_i      (in_op),
    .range_first_i    (in_first),
    .range_last_i     (in_last),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .set_count_i      (set_count),
    .overflow_i       (overflow),
    .pending_o        (pending),
    .fails_o          (fails)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic pos_t pick_pos(pos_t len);
    return (len == '0) ? pos_t'($urandom_range(0, 3)) : pos_t'($urandom_range(1, len));
  endfunction

  task automatic send_item(logic op, pos_t first, pos_t last);
    int gap;
    gap = idle_en ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_first <= first;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(logic fill);
    int   pick;
    logic op;
    pos_t f, l, t;
    pick = fill ? $urandom_range(0, 69) : $urandom_range(0, 99);
    op   = ($urandom_range(0, 9) < (fill ? 8 : 6)) ? OpSet : OpClear;
    f    = pick_pos(cur_len);
    l    = f + pos_t'($urandom_range(0, 3));
    if (pick >= 70 && pick < 85) begin
      l = pick_pos(cur_len);
      if (l < f) begin
        t = f; f = l; l = t;
      end
    end else if (pick >= 85 && pick < 93) begin
      // zero first position, range past the line, reversed or wild bounds
      case ($urandom_range(0, 3))
        0: f = '0;
        1: l = pos_t'($urandom);
        2: l = f - pos_t'(1);
        default: begin
          f = pos_t'($urandom);
          l = pos_t'($urandom);
        end
      endcase
    end else if (pick >= 93) begin
      f = 1;
      l = cur_len;
    end
    send_item(op, f, l);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_len(pos_t len);
    cfg_valid <= 1'b1;
    cfg_len   <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_len = len;
  endtask

  // receiver, with two long hold-offs to back the block up
  initial begin
    int stall, got;
    got = 0;
    wait (rst_n);
    forever begin
      if (got == 150 || got == 800) stall = 400;
      else stall = idle_en ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  initial begin
    pos_t lens [NumPhases];
    pos_t spacing;
    int   n;
    logic fill;
    lens = '{LineLenRst, 31'd1, 31'd0, 31'h4000_0000, 31'h3FFF_FFFF, 31'd37,
             pos_t'($urandom_range(200, 5000)), pos_t'($urandom_range(1, 31'h4000_0000)),
             31'd300};
    fill = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OpSet,   1,              1024);
    send_item(OpClear, 0,              0);
    send_item(OpClear, 1,              1);
    send_item(OpClear, 1024,           1024);
    send_item(OpSet,   500,            31'h7FFF_FFFF);
    send_item(OpClear, 2000,           3000);
    send_item(OpClear, 0,              10);
    send_item(OpSet,   300,            200);
    send_item(OpSet,   400,            400);
    send_item(OpClear, 100,            600);
    send_item(OpClear, 1,              31'h4000_0000);
    send_item(OpSet,   1,              1);
    send_item(OpSet,   31'h7FFF_FFFF,  31'h7FFF_FFFF);
    send_item(OpSet,   31'h2AAA_AAAA,  31'h5555_5555);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_len(lens[ph]);
      end
      idle_en = (ph % 3 != 2);
      n = (cur_len < 2) ? 20 : 150;
      if (cur_len >= 2) begin
        // full line, then spread point sets until the table runs out of room
        send_item(OpSet, 1, cur_len);
        spacing = (cur_len / 34 == 0) ? pos_t'(1) : pos_t'(cur_len / 34);
        for (int k = 0; k < 34; k++) begin
          send_item(OpSet, pos_t'(k) * spacing + pos_t'($urandom_range(1, spacing)),
                    pos_t'(k) * spacing + pos_t'($urandom_range(1, spacing)));
        end
      end
      for (int i = 0; i < n; i++) begin
        if (i % 30 == 0) fill = 1'($urandom_range(0, 1));
        send_random(fill);
      end
    end

    wait_idle();
    repeat (150) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
